// ===== src/scanline_frame_timer_unit_defines.svh =====
// assertion macros shared by the timer modules
`ifndef SCANLINE_FRAME_TIMER_UNIT_DEFINES_SVH
`define SCANLINE_FRAME_TIMER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SFTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SFTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sftu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sftu_pkg;

    localparam int CNT_W    = 9;
    localparam int SPRITE_W = 8;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int IDX_W    = 2;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_DOTS_PER_LINE     = 2'd0;
    localparam reg_idx_t REG_LINES_PER_FRAME   = 2'd1;
    localparam reg_idx_t REG_VBLANK_START_LINE = 2'd2;

    localparam logic [CNT_W-1:0] DOTS_RESET   = 9'd341;
    localparam logic [CNT_W-1:0] LINES_RESET  = 9'd262;
    localparam logic [CNT_W-1:0] VBLANK_RESET = 9'd241;

    typedef struct packed {
        logic [CNT_W-1:0] dots_per_line;
        logic [CNT_W-1:0] lines_per_frame;
        logic [CNT_W-1:0] vblank_start_line;
    } cfg_t;

    typedef struct packed {
        logic                tick;
        logic                nmi_enable;
        logic [SPRITE_W-1:0] sprite0_y;
        logic                clear_vblank;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] scanline;
        logic             line_start;
        logic             frame_start;
        logic             vblank_flag;
        logic             sprite0_hit;
        logic             nmi_pulse;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/sftu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sftu_in_if;
    logic                         valid;
    logic                         ready;
    logic                         tick;
    logic                         nmi_enable;
    logic [sftu_pkg::SPRITE_W-1:0] sprite0_y;
    logic                         clear_vblank;

    modport source (output valid, tick, nmi_enable, sprite0_y, clear_vblank, input ready);
    modport sink   (input valid, tick, nmi_enable, sprite0_y, clear_vblank, output ready);
endinterface

interface sftu_out_if;
    logic                       valid;
    logic                       ready;
    logic [sftu_pkg::CNT_W-1:0] scanline;
    logic                       line_start;
    logic                       frame_start;
    logic                       vblank_flag;
    logic                       sprite0_hit;
    logic                       nmi_pulse;

    modport source (output valid, scanline, line_start, frame_start, vblank_flag,
                    sprite0_hit, nmi_pulse, input ready);
    modport sink   (input valid, scanline, line_start, frame_start, vblank_flag,
                    sprite0_hit, nmi_pulse, output ready);
endinterface

`default_nettype wire

// ===== src/sftu_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sftu_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sftu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sftu_pkg::PDATA_W-1:0] pwdata,
    output logic      [sftu_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output sftu_pkg::cfg_t                    cfg
);

    sftu_pkg::cfg_t     cfg_reg;
    sftu_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = paddr[sftu_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dots_per_line     <= sftu_pkg::DOTS_RESET;
            cfg_reg.lines_per_frame   <= sftu_pkg::LINES_RESET;
            cfg_reg.vblank_start_line <= sftu_pkg::VBLANK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                sftu_pkg::REG_DOTS_PER_LINE:
                    cfg_reg.dots_per_line <= pwdata[sftu_pkg::CNT_W-1:0];
                sftu_pkg::REG_LINES_PER_FRAME:
                    cfg_reg.lines_per_frame <= pwdata[sftu_pkg::CNT_W-1:0];
                sftu_pkg::REG_VBLANK_START_LINE:
                    cfg_reg.vblank_start_line <= pwdata[sftu_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            sftu_pkg::REG_DOTS_PER_LINE:
                prdata[sftu_pkg::CNT_W-1:0] = cfg_reg.dots_per_line;
            sftu_pkg::REG_LINES_PER_FRAME:
                prdata[sftu_pkg::CNT_W-1:0] = cfg_reg.lines_per_frame;
            sftu_pkg::REG_VBLANK_START_LINE:
                prdata[sftu_pkg::CNT_W-1:0] = cfg_reg.vblank_start_line;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sftu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "scanline_frame_timer_unit_defines.svh"

module sftu_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sftu_pkg::cfg_t      cfg,
    input  wire logic                accept,
    input  wire sftu_pkg::in_item_t  item,
    output sftu_pkg::out_item_t      result
);

    localparam int CW = sftu_pkg::CNT_W;

    logic [CW-1:0] dot_reg, dot_next;
    logic [CW-1:0] line_reg, line_next;
    logic          vblank_reg, vblank_next;
    logic          hit_reg, hit_next;
    logic          nmi_done_reg, nmi_done_next;

    logic [CW:0]   dot_inc;
    logic [CW:0]   line_inc;
    logic          new_line;
    logic          new_frame;
    logic          nmi;

    assign dot_inc  = {1'b0, dot_reg} + {{CW{1'b0}}, 1'b1};
    assign line_inc = {1'b0, line_reg} + {{CW{1'b0}}, 1'b1};

    always_comb
    begin
        dot_next      = dot_reg;
        line_next     = line_reg;
        vblank_next   = vblank_reg && !item.clear_vblank;
        hit_next      = hit_reg;
        nmi_done_next = nmi_done_reg;
        new_line      = 1'b0;
        new_frame     = 1'b0;
        nmi           = 1'b0;

        if (item.tick)
        begin
            if (dot_inc >= {1'b0, cfg.dots_per_line})
            begin
                dot_next  = '0;
                line_next = (line_inc >= {1'b0, cfg.lines_per_frame}) ? '0 : line_inc[CW-1:0];
                new_line  = 1'b1;
            end
            else
            begin
                dot_next = dot_inc[CW-1:0];
            end
        end

        // line start rules, in order
        if (new_line)
        begin
            if (line_next == '0)
            begin
                nmi_done_next = 1'b0;
                new_frame     = 1'b1;
            end
            if (line_next < cfg.vblank_start_line && {1'b0, item.sprite0_y} == line_next)
            begin
                hit_next = 1'b1;
            end
            if (line_next == cfg.vblank_start_line)
            begin
                vblank_next = 1'b1;
            end
            if (line_next >= cfg.vblank_start_line && vblank_next && item.nmi_enable
                && !nmi_done_next)
            begin
                nmi           = 1'b1;
                nmi_done_next = 1'b1;
            end
            if (cfg.lines_per_frame != '0 && line_next == cfg.lines_per_frame - 9'd1)
            begin
                hit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg      <= '0;
            line_reg     <= '0;
            vblank_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            nmi_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            dot_reg      <= dot_next;
            line_reg     <= line_next;
            vblank_reg   <= vblank_next;
            hit_reg      <= hit_next;
            nmi_done_reg <= nmi_done_next;
        end
    end

    assign result.scanline    = line_next;
    assign result.line_start  = new_line;
    assign result.frame_start = new_frame;
    assign result.vblank_flag = vblank_next;
    assign result.sprite0_hit = hit_next;
    assign result.nmi_pulse   = nmi;

    `SFTU_ASSERT_NOW(a_frame_on_line_zero, new_frame, new_line && line_next == '0,
        "frame start without a new line 0")
    `SFTU_ASSERT_NOW(a_nmi_needs_vblank, nmi, vblank_next && item.nmi_enable,
        "interrupt without vblank and enable")
    `SFTU_ASSERT_NEXT(a_nmi_sets_done, accept && nmi, nmi_done_reg,
        "interrupt did not mark the frame as done")
    `SFTU_ASSERT_NEXT(a_wrap_clears_dot, accept && new_line, dot_reg == '0,
        "dot counter not cleared at line start")

endmodule

`default_nettype wire

// ===== src/sftu_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "scanline_frame_timer_unit_defines.svh"

module sftu_out_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sftu_pkg::out_item_t push_data,
    output logic                     space,
    output logic                     head_valid,
    input  wire logic                pop_ready,
    output sftu_pkg::out_item_t      head
);

    sftu_pkg::out_item_t head_reg, head_next;
    sftu_pkg::out_item_t tail_reg, tail_next;
    logic [1:0]          count_reg, count_next;
    logic                pop;

    assign space      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_valid && pop_ready;
    assign head       = head_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = push_data;
                else
                    tail_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // one beat leaves, one arrives: depth stays
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `SFTU_ASSERT_NOW(a_count_bound, 1'b1, count_reg != 2'd3, "buffer count out of range")
    `SFTU_ASSERT_NOW(a_no_push_full, push, count_reg != 2'd2, "push into a full buffer")
    `SFTU_ASSERT_NEXT(a_stall_holds, head_valid && !pop_ready, head_valid && $stable(head_reg),
        "stalled head beat changed")

endmodule

`default_nettype wire

// ===== src/scanline_frame_timer_unit.sv =====
// scanline frame timer
// din carries one beat per video cycle (tick, nmi_enable, sprite0_y, clear_vblank);
// dout returns exactly one beat per input beat with the scanline, the line and
// frame start pulses, the vblank and sprite zero hit flags and the interrupt pulse.
// both channels are valid/ready; a beat moves when both are high.
// the result of a beat is computed combinationally and written into the buffer at
// the accepting edge; din takes one beat per cycle while the buffer has space, and
// counters and flags register at that edge; dout offers results in arrival order.
// a two-entry result buffer sits between the timer state and dout, so din stays
// ready while one result waits; din.ready drops only when both entries are held
// by a stalled receiver, and no result is dropped or repeated.
// the apb port writes dots_per_line (0x0), lines_per_frame (0x4) and
// vblank_start_line (0x8); write only while no result is outstanding.
// reset clears the dot and line counters, the vblank, hit and interrupt-done flags
// and empties the buffer; the registers return to 341, 262 and 241.
`timescale 1ns / 1ps
`default_nettype none

module scanline_frame_timer_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    sftu_in_if.sink                           din,
    sftu_out_if.source                        dout,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sftu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sftu_pkg::PDATA_W-1:0] pwdata,
    output logic      [sftu_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    sftu_pkg::cfg_t      cfg;
    sftu_pkg::in_item_t  in_item;
    sftu_pkg::out_item_t result;
    sftu_pkg::out_item_t head;
    logic                space;
    logic                accept;

    assign in_item.tick         = din.tick;
    assign in_item.nmi_enable   = din.nmi_enable;
    assign in_item.sprite0_y    = din.sprite0_y;
    assign in_item.clear_vblank = din.clear_vblank;

    assign din.ready = space;
    assign accept    = din.valid && space;

    sftu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sftu_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (in_item),
        .result (result)
    );

    sftu_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .space      (space),
        .head_valid (dout.valid),
        .pop_ready  (dout.ready),
        .head       (head)
    );

    assign dout.scanline    = head.scanline;
    assign dout.line_start  = head.line_start;
    assign dout.frame_start = head.frame_start;
    assign dout.vblank_flag = head.vblank_flag;
    assign dout.sprite0_hit = head.sprite0_hit;
    assign dout.nmi_pulse   = head.nmi_pulse;

endmodule

`default_nettype wire

// ===== dv/scanline_frame_timer_unit_checker.sv =====
`timescale 1ns / 1ps

module scanline_frame_timer_unit_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    sftu_in_if                           din,
    sftu_out_if                          dout,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sftu_pkg::PADDR_W-1:0] paddr,
    input  logic [sftu_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending_count
);

    sftu_pkg::cfg_t             timer_cfg;
    logic [sftu_pkg::CNT_W-1:0] dot_pos;
    logic [sftu_pkg::CNT_W-1:0] line_pos;
    logic                       vblank_set;
    logic                       hit_set;
    logic                       nmi_fired;
    sftu_pkg::out_item_t        pending_timing[$];

    // timing state after one input beat, updated in place
    function automatic sftu_pkg::out_item_t advance_timer(input sftu_pkg::in_item_t beat);
        sftu_pkg::out_item_t res;
        int                  nd;
        int                  nl;
        logic                new_line;
        res = '0;
        new_line = 1'b0;
        if (beat.clear_vblank)
            vblank_set = 1'b0;
        if (beat.tick)
        begin
            nd = int'(dot_pos) + 1;
            if (nd >= int'(timer_cfg.dots_per_line))
            begin
                nl = int'(line_pos) + 1;
                dot_pos = '0;
                line_pos = (nl >= int'(timer_cfg.lines_per_frame)) ? '0
                                                                   : sftu_pkg::CNT_W'(nl);
                new_line = 1'b1;
            end
            else
                dot_pos = sftu_pkg::CNT_W'(nd);
        end
        if (new_line)
        begin
            if (line_pos == '0)
            begin
                nmi_fired = 1'b0;
                res.frame_start = 1'b1;
            end
            if (line_pos < timer_cfg.vblank_start_line
                && sftu_pkg::CNT_W'(beat.sprite0_y) == line_pos)
                hit_set = 1'b1;
            if (line_pos == timer_cfg.vblank_start_line)
                vblank_set = 1'b1;
            if (line_pos >= timer_cfg.vblank_start_line && vblank_set && beat.nmi_enable
                && !nmi_fired)
            begin
                res.nmi_pulse = 1'b1;
                nmi_fired = 1'b1;
            end
            // last line of the frame drops the hit flag
            if (timer_cfg.lines_per_frame != '0
                && int'(line_pos) == int'(timer_cfg.lines_per_frame) - 1)
                hit_set = 1'b0;
        end
        res.scanline    = line_pos;
        res.line_start  = new_line;
        res.vblank_flag = vblank_set;
        res.sprite0_hit = hit_set;
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sftu_pkg::in_item_t  beat;
        sftu_pkg::out_item_t want;
        if (!rst_n)
        begin
            timer_cfg.dots_per_line     = sftu_pkg::DOTS_RESET;
            timer_cfg.lines_per_frame   = sftu_pkg::LINES_RESET;
            timer_cfg.vblank_start_line = sftu_pkg::VBLANK_RESET;
            dot_pos    = '0;
            line_pos   = '0;
            vblank_set = 1'b0;
            hit_set    = 1'b0;
            nmi_fired  = 1'b0;
            pending_timing.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (sftu_pkg::reg_idx_t'(paddr[sftu_pkg::PADDR_W-1:2]))
                    sftu_pkg::REG_DOTS_PER_LINE:
                        timer_cfg.dots_per_line = pwdata[sftu_pkg::CNT_W-1:0];
                    sftu_pkg::REG_LINES_PER_FRAME:
                        timer_cfg.lines_per_frame = pwdata[sftu_pkg::CNT_W-1:0];
                    sftu_pkg::REG_VBLANK_START_LINE:
                        timer_cfg.vblank_start_line = pwdata[sftu_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (din.valid && din.ready)
            begin
                beat.tick         = din.tick;
                beat.nmi_enable   = din.nmi_enable;
                beat.sprite0_y    = din.sprite0_y;
                beat.clear_vblank = din.clear_vblank;
                pending_timing.push_back(advance_timer(beat));
            end
            if (dout.valid && dout.ready)
            begin
                if (pending_timing.size() == 0)
                begin
                    $error("result beat with no expectation waiting, scanline %0d",
                           dout.scanline);
                    fail_count++;
                end
                else
                begin
                    want = pending_timing.pop_front();
                    check_field("scanline", want.scanline, dout.scanline);
                    check_field("line_start", want.line_start, dout.line_start);
                    check_field("frame_start", want.frame_start, dout.frame_start);
                    check_field("vblank_flag", want.vblank_flag, dout.vblank_flag);
                    check_field("sprite0_hit", want.sprite0_hit, dout.sprite0_hit);
                    check_field("nmi_pulse", want.nmi_pulse, dout.nmi_pulse);
                end
            end
            pending_count = pending_timing.size();
        end
    end

endmodule

// ===== dv/scanline_frame_timer_unit_tb.sv =====
`timescale 1ns / 1ps

module scanline_frame_timer_unit_tb;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sftu_pkg::PADDR_W-1:0] paddr;
    logic [sftu_pkg::PDATA_W-1:0] pwdata;
    logic [sftu_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    int                           fail_count;
    int                           pending_count;

    int in_count  = 0;
    int out_count = 0;
    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit hold_req  = 1'b0;

    sftu_in_if  din_bus();
    sftu_out_if dout_bus();

    scanline_frame_timer_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_bus),
        .dout    (dout_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scanline_frame_timer_unit_checker timing_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din_bus),
        .dout          (dout_bus),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic sftu_pkg::in_item_t mk(input bit t, input bit n, input int y,
                                              input bit c);
        sftu_pkg::in_item_t beat;
        beat.tick         = t;
        beat.nmi_enable   = n;
        beat.sprite0_y    = sftu_pkg::SPRITE_W'(y);
        beat.clear_vblank = c;
        return beat;
    endfunction

    // sprite y mostly lands between 0 and the line count of the frame (capped at 255)
    function automatic sftu_pkg::in_item_t random_beat(input int span, input bit all_ticks);
        int top_y;
        top_y = (span > 255) ? 255 : span;
        return mk(all_ticks ? 1'b1 : ($urandom_range(0, 99) < 85),
                  $urandom_range(0, 99) < 75,
                  ($urandom_range(0, 9) < 7) ? $urandom_range(0, top_y)
                                             : $urandom_range(0, 255),
                  $urandom_range(0, 99) < 15);
    endfunction

    task automatic send_beat(input sftu_pkg::in_item_t beat);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            din_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_bus.valid        <= 1'b1;
        din_bus.tick         <= beat.tick;
        din_bus.nmi_enable   <= beat.nmi_enable;
        din_bus.sprite0_y    <= beat.sprite0_y;
        din_bus.clear_vblank <= beat.clear_vblank;
        @(posedge clk);
        while (!din_bus.ready) @(posedge clk);
        in_count++;
    endtask

    task automatic wait_idle();
        din_bus.valid <= 1'b0;
        @(posedge clk);
        while (out_count != in_count) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input sftu_pkg::reg_idx_t idx,
                             input logic [sftu_pkg::CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= sftu_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timing(input int dots, input int lines, input int vbl);
        wait_idle();
        write_reg(sftu_pkg::REG_DOTS_PER_LINE, sftu_pkg::CNT_W'(dots));
        write_reg(sftu_pkg::REG_LINES_PER_FRAME, sftu_pkg::CNT_W'(lines));
        write_reg(sftu_pkg::REG_VBLANK_START_LINE, sftu_pkg::CNT_W'(vbl));
    endtask

    task automatic run_frames(input int beats, input int dots, input int lines, input int vbl,
                              input bit all_ticks, input int pause_at);
        set_timing(dots, lines, vbl);
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        for (int i = 0; i < beats; i++)
        begin
            if (i == pause_at)
                wait_idle();
            send_beat(random_beat(lines, all_ticks));
        end
    endtask

    // result side: random stalls per beat, one long hold-off on request
    initial
    begin
        int gap;
        dout_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                dout_bus.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                dout_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            dout_bus.ready <= 1'b1;
            @(posedge clk);
            while (!dout_bus.valid) @(posedge clk);
            out_count++;
        end
    end

    initial
    begin
        int d;
        int l;
        int v;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        din_bus.valid        <= 1'b0;
        din_bus.tick         <= 1'b0;
        din_bus.nmi_enable   <= 1'b0;
        din_bus.sprite0_y    <= '0;
        din_bus.clear_vblank <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing, no line start yet
        send_beat(mk(0, 0, 0, 1));
        send_beat(mk(1, 1, 255, 0));
        send_beat(mk(0, 0, 0, 0));

        // tiny frame: 2 dots, 4 lines, vblank at line 2
        set_timing(2, 4, 2);
        send_beat(mk(1, 1, 1, 0));
        send_beat(mk(1, 1, 1, 0));      // no line start; stays on line 1 with the hit set
        send_beat(mk(0, 0, 255, 1));
        send_beat(mk(1, 0, 1, 0));
        send_beat(mk(1, 0, 1, 0));      // vblank line with interrupt disabled
        send_beat(mk(1, 1, 0, 0));
        send_beat(mk(1, 1, 0, 0));      // still on the last line after the late interrupt, hit cleared
        send_beat(mk(1, 1, 0, 1));
        send_beat(mk(1, 1, 0, 0));      // on line 0 after the frame start, hit set
        send_beat(mk(1, 1, 255, 0));
        send_beat(mk(1, 1, 255, 0));
        send_beat(mk(1, 1, 255, 0));
        send_beat(mk(1, 1, 255, 1));    // clears vblank while on the vblank line
        send_beat(mk(0, 1, 0, 0));
        send_beat(mk(1, 1, 3, 0));
        send_beat(mk(1, 1, 3, 0));
        send_beat(mk(1, 0, 0, 0));
        // frame shrinks to two lines while on line 0
        wait_idle();
        write_reg(sftu_pkg::REG_LINES_PER_FRAME, sftu_pkg::CNT_W'(2));
        send_beat(mk(1, 1, 0, 0));

        run_frames(40, 511, 511, 510, 1'b0, -1);
        run_frames(80, 2, 2, 1, 1'b0, -1);

        for (int p = 0; p < 8; p++)
        begin
            d = (p % 3 == 2) ? $urandom_range(2, 20) : $urandom_range(2, 6);
            l = $urandom_range(2, 12);
            v = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 510) : $urandom_range(1, l - 1);
            if (p == 2)
            begin
                set_timing(d, l, v);
                hold_req = 1'b1;
                tx_idle  = 1'b0;
                for (int i = 0; i < 25; i++)
                    send_beat(random_beat(l, 1'b0));
            end
            else
                run_frames(25, d, l, v, 1'b0, (p == 4) ? 12 : -1);
        end

        // long frame running past scanline 255
        run_frames(520, 2, 511, 510, 1'b1, -1);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
